[rtl/kga_pkg.sv]
package kga_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 64;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int CELL_AW   = $clog2(CELLS);

  // Field widths
  localparam int COORD_W = 6;
  localparam int SAMP_W  = 16;
  localparam int WPS_W   = 11;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = 48;
  localparam int ACC_W   = 40;

  localparam logic [WPS_W-1:0] WPS_RESET = WPS_W'(16);
  localparam logic [WPS_W-1:0] SLOT_MAX  = {WPS_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  // Header fields of one sample
  typedef struct packed {
    logic signed [SAMP_W-1:0]  sample_real;
    logic signed [SAMP_W-1:0]  sample_imag;
    logic        [SAMP_W-1:0]  density_comp;
    logic        [COORD_W-1:0] x_low;
    logic        [COORD_W-1:0] x_high;
    logic        [COORD_W-1:0] y_low;
    logic        [COORD_W-1:0] y_high;
  } hdr_t;

  // Window walker status
  typedef struct packed {
    logic               active;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } win_stat_t;

  // Read request, issued in the accept cycle
  typedef struct packed {
    logic               en;
    logic [CELL_AW-1:0] addr;
  } rd_req_t;

  // Write-back request: an add in the cycle after its read, a clear once the output is free
  typedef struct packed {
    logic                     add;
    logic                     zero;
    logic [CELL_AW-1:0]       addr;
    logic signed [PROD_W-1:0] prod_real;
    logic signed [PROD_W-1:0] prod_imag;
  } wb_req_t;

  function automatic logic in_grid(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return (32'(x) < 32'(GRID_SIZE)) && (32'(y) < 32'(GRID_SIZE));
  endfunction

  function automatic logic [CELL_AW-1:0] cell_idx(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    return CELL_AW'(x) * CELL_AW'(GRID_SIZE) + CELL_AW'(y);
  endfunction

endpackage

[rtl/kga_window.sv]
module kga_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kga_pkg::WPS_W-1:0]    cfg_wdata_i,
  input  logic                         load_i,
  input  logic                         step_i,
  input  kga_pkg::hdr_t                hdr_i,
  output kga_pkg::win_stat_t           stat_o,
  output logic signed [kga_pkg::SCALE_W-1:0] scaled_real_o,
  output logic signed [kga_pkg::SCALE_W-1:0] scaled_imag_o
);
  import kga_pkg::*;

  logic [WPS_W-1:0]          wps_q;
  logic signed [SCALE_W-1:0] scaled_real_q, scaled_real_d;
  logic signed [SCALE_W-1:0] scaled_imag_q, scaled_imag_d;
  logic [COORD_W-1:0]        xl_q, xl_d, xh_q, xh_d, yl_q, yl_d, yh_q, yh_d;
  logic [COORD_W-1:0]        px_q, px_d, py_q, py_d;
  logic [WPS_W-1:0]          slot_q, slot_d, slot_inc;
  logic                      done_q, done_d;
  logic                      active;
  logic signed [SAMP_W:0]    dcf_s;
  logic signed [SAMP_W*2:0]  mul_re, mul_im;

  assign active = !done_q && (slot_q < wps_q);
  assign dcf_s  = $signed({1'b0, hdr_i.density_comp});
  assign mul_re = hdr_i.sample_real * dcf_s;
  assign mul_im = hdr_i.sample_imag * dcf_s;
  assign slot_inc = (slot_q == SLOT_MAX) ? slot_q : slot_q + WPS_W'(1);

  // Header load and column-major walk
  always_comb begin
    scaled_real_d = scaled_real_q;
    scaled_imag_d = scaled_imag_q;
    xl_d = xl_q;
    xh_d = xh_q;
    yl_d = yl_q;
    yh_d = yh_q;
    px_d = px_q;
    py_d = py_q;
    slot_d = slot_q;
    done_d = done_q;
    if (load_i) begin
      scaled_real_d = mul_re[SCALE_W-1:0];
      scaled_imag_d = mul_im[SCALE_W-1:0];
      xl_d = hdr_i.x_low;
      xh_d = hdr_i.x_high;
      yl_d = hdr_i.y_low;
      yh_d = hdr_i.y_high;
      px_d = hdr_i.x_low;
      py_d = hdr_i.y_low;
      slot_d = '0;
      done_d = (hdr_i.x_high < hdr_i.x_low) || (hdr_i.y_high < hdr_i.y_low);
    end else if (step_i) begin
      if (active) begin
        if (py_q == yh_q) begin
          py_d = yl_q;
          if (px_q == xh_q) begin
            done_d = 1'b1;
          end else begin
            px_d = px_q + COORD_W'(1);
          end
        end else begin
          py_d = py_q + COORD_W'(1);
        end
      end
      slot_d = slot_inc;
      if (slot_inc >= wps_q) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wps_q         <= WPS_RESET;
      scaled_real_q <= '0;
      scaled_imag_q <= '0;
      xl_q   <= '0;
      xh_q   <= '0;
      yl_q   <= '0;
      yh_q   <= '0;
      px_q   <= '0;
      py_q   <= '0;
      slot_q <= '0;
      done_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        wps_q <= cfg_wdata_i;
      end
      scaled_real_q <= scaled_real_d;
      scaled_imag_q <= scaled_imag_d;
      xl_q   <= xl_d;
      xh_q   <= xh_d;
      yl_q   <= yl_d;
      yh_q   <= yh_d;
      px_q   <= px_d;
      py_q   <= py_d;
      slot_q <= slot_d;
      done_q <= done_d;
    end
  end

  assign stat_o.active = active;
  assign stat_o.pos_x  = px_q;
  assign stat_o.pos_y  = py_q;
  assign scaled_real_o = scaled_real_q;
  assign scaled_imag_o = scaled_imag_q;

endmodule

[rtl/kga_accum.sv]
module kga_accum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kga_pkg::rd_req_t                 rd_i,
  input  kga_pkg::wb_req_t                 wb_i,
  output logic                             init_done_o,
  output logic signed [kga_pkg::ACC_W-1:0] rd_real_o,
  output logic signed [kga_pkg::ACC_W-1:0] rd_imag_o
);
  import kga_pkg::*;

  // Real part in the upper half, imaginary in the lower
  logic [2*ACC_W-1:0] mem [CELLS];
  logic [2*ACC_W-1:0] rd_data_q;

  logic               busy_q;
  logic [CELL_AW-1:0] sweep_q;

  logic               we;
  logic [CELL_AW-1:0] waddr;
  logic [2*ACC_W-1:0] wdata;
  logic signed [ACC_W-1:0] sum_re, sum_im;

  // Floor shift by 16 is an arithmetic part-select, then a saturating add
  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                     logic signed [PROD_W-1:0] p);
    logic signed [SCALE_W-1:0] c;
    logic signed [ACC_W:0]     s;
    c = p[PROD_W-1:16];
    s = {a[ACC_W-1], a} + {{(ACC_W+1-SCALE_W){c[SCALE_W-1]}}, c};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  assign sum_re = sat_add(rd_data_q[2*ACC_W-1:ACC_W], wb_i.prod_real);
  assign sum_im = sat_add(rd_data_q[ACC_W-1:0], wb_i.prod_imag);

  // Clearing sweep has the write port until it finishes
  always_comb begin
    we    = 1'b0;
    waddr = wb_i.addr;
    wdata = '0;
    if (busy_q) begin
      we    = 1'b1;
      waddr = sweep_q;
    end else if (wb_i.add) begin
      we    = 1'b1;
      wdata = {sum_re, sum_im};
    end else if (wb_i.zero) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else if (busy_q) begin
      if (sweep_q == CELL_AW'(CELLS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        sweep_q <= sweep_q + CELL_AW'(1);
      end
    end
  end

  // Grid memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign init_done_o = !busy_q;
  assign rd_real_o   = rd_data_q[2*ACC_W-1:ACC_W];
  assign rd_imag_o   = rd_data_q[ACC_W-1:0];

endmodule

[rtl/kspace_gridding_accumulator_unit.sv]
// K-space gridding accumulator: a 64 x 64 grid of complex 40-bit saturating
// accumulators in one on-chip memory, fed by a header beat (sample, density
// factor, window) followed by kernel weight beats that walk the window
// column-major, plus read beats that return and optionally clear one cell.
// After reset the unit sweeps the grid to zero, one cell per cycle, with
// s_axis_tready low; configuration writes are taken meanwhile. A header or a
// weight that touches no cell finishes on accept; a weight that updates a cell
// reads the memory, then adds and writes back through the single write port; a
// read fetches the cell, then waits for the output register to drain. One beat
// is in work at a time.
module kspace_gridding_accumulator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration: weights_per_sample
  input  logic          cfg_we_i,
  input  logic [10:0]   cfg_wdata_i,
  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: sample_real[15:0], sample_imag[31:16], density_comp[47:32],
  //   x_low[53:48], x_high[59:54], y_low[65:60], y_high[71:66],
  //   weight[87:72], read_x[93:88], read_y[99:94], clear_after_read[100],
  //   zero pad[103:101]
  input  logic [103:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]    s_axis_tuser,
  // Output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: grid_real[39:0], grid_imag[79:40]
  output logic [79:0]   m_axis_tdata
);
  import kga_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  hdr_t                      hdr;
  logic signed [SAMP_W-1:0]  weight;
  logic [COORD_W-1:0]        read_x, read_y;
  logic                      clear_after_read;
  kind_e                     kind;

  win_stat_t                 win_stat;
  logic signed [SCALE_W-1:0] scaled_re, scaled_im;
  logic                      init_done;
  logic signed [ACC_W-1:0]   rd_re, rd_im;

  logic s_fire, load, step, hit, out_free;
  rd_req_t rd_req;
  wb_req_t wb_req;

  logic [CELL_AW-1:0]       addr_q, addr_d;
  logic                     clr_q, clr_d;
  logic                     oob_q, oob_d;
  logic signed [PROD_W-1:0] prod_re_q, prod_re_d, prod_im_q, prod_im_d;
  logic                     m_valid_q, m_valid_d;
  logic [2*ACC_W-1:0]       m_data_q, m_data_d;

  // Field unpacking
  assign hdr.sample_real  = s_axis_tdata[15:0];
  assign hdr.sample_imag  = s_axis_tdata[31:16];
  assign hdr.density_comp = s_axis_tdata[47:32];
  assign hdr.x_low        = s_axis_tdata[53:48];
  assign hdr.x_high       = s_axis_tdata[59:54];
  assign hdr.y_low        = s_axis_tdata[65:60];
  assign hdr.y_high       = s_axis_tdata[71:66];
  assign weight           = s_axis_tdata[87:72];
  assign read_x           = s_axis_tdata[93:88];
  assign read_y           = s_axis_tdata[99:94];
  assign clear_after_read = s_axis_tdata[100];
  assign kind             = kind_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE) && init_done;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign load          = s_fire && (kind == KIND_HEADER);
  assign step          = s_fire && (kind == KIND_WEIGHT);
  assign hit           = win_stat.active && (weight > 0) &&
                         in_grid(win_stat.pos_x, win_stat.pos_y);
  assign out_free      = !m_valid_q || m_axis_tready;

  kga_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .load_i        (load),
    .step_i        (step),
    .hdr_i         (hdr),
    .stat_o        (win_stat),
    .scaled_real_o (scaled_re),
    .scaled_imag_o (scaled_im)
  );

  // Sequencer: issue the read on accept; an add finishes in ST_ADD, a read once the output is free
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    clr_d     = clr_q;
    oob_d     = oob_q;
    prod_re_d = prod_re_q;
    prod_im_d = prod_im_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    rd_req.en   = 1'b0;
    rd_req.addr = cell_idx(win_stat.pos_x, win_stat.pos_y);
    wb_req.add  = 1'b0;
    wb_req.zero = 1'b0;
    wb_req.addr = addr_q;
    wb_req.prod_real = prod_re_q;
    wb_req.prod_imag = prod_im_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (kind)
            KIND_WEIGHT: begin
              if (hit) begin
                rd_req.en = 1'b1;
                addr_d    = rd_req.addr;
                prod_re_d = weight * scaled_re;
                prod_im_d = weight * scaled_im;
                state_d   = ST_ADD;
              end
            end
            KIND_READ: begin
              rd_req.addr = cell_idx(read_x, read_y);
              oob_d       = !in_grid(read_x, read_y);
              rd_req.en   = !oob_d;
              addr_d      = rd_req.addr;
              clr_d       = clear_after_read;
              state_d     = ST_RESP;
            end
            default: begin
              // header handled in the walker; unused kind does nothing
            end
          endcase
        end
      end
      ST_ADD: begin
        wb_req.add = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) begin
          m_valid_d   = 1'b1;
          m_data_d    = oob_q ? '0 : {rd_im, rd_re};
          wb_req.zero = clr_q && !oob_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  kga_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd_req),
    .wb_i        (wb_req),
    .init_done_o (init_done),
    .rd_real_o   (rd_re),
    .rd_imag_o   (rd_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    clr_q     <= clr_d;
    oob_q     <= oob_d;
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[rtl/kga_checker.sv]
module kga_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata
);
  import kga_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Stalled output beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // A read beat keeps the unit busy in the cycle after it is accepted
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == KIND_READ) |=> !s_axis_tready)
    else $error("input accepted while a read is in flight");

  // Header and unused beats leave the unit ready again in the next cycle
  a_hdr_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser != KIND_WEIGHT) && (s_axis_tuser != KIND_READ)
    |=> s_axis_tready)
    else $error("unit stalled after a single-cycle beat");

endmodule

bind kspace_gridding_accumulator_unit kga_checker u_kga_checker (.*);

[sim/tb.sv]
module tb;
  import kga_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One input beat, unpacked into its fields
  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  s_re;
    logic signed [15:0]  s_im;
    logic [15:0]         dcf;
    logic [5:0]          xl;
    logic [5:0]          xh;
    logic [5:0]          yl;
    logic [5:0]          yh;
    logic signed [15:0]  wgt;
    logic [5:0]          rx;
    logic [5:0]          ry;
    logic                clr;
  } beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } cell_val_t;

  // Mirror of the grid and the window walker; predicts every read beat
  class grid_mirror;
    logic signed [ACC_W-1:0]   acc_re [CELLS];
    logic signed [ACC_W-1:0]   acc_im [CELLS];
    logic signed [SCALE_W-1:0] scaled_re;
    logic signed [SCALE_W-1:0] scaled_im;
    logic [COORD_W-1:0]        wx_lo, wx_hi, wy_lo, wy_hi, px, py;
    logic [WPS_W-1:0]          slots;
    logic [WPS_W-1:0]          wps;
    bit                        win_done;
    cell_val_t                 pending_cells[$];
    int                        mismatches;

    function new();
      foreach (acc_re[i]) begin
        acc_re[i] = '0;
        acc_im[i] = '0;
      end
      scaled_re = '0;
      scaled_im = '0;
      wx_lo = '0; wx_hi = '0; wy_lo = '0; wy_hi = '0;
      px = '0; py = '0;
      slots = '0;
      wps = WPS_RESET;
      win_done = 1'b1;
      mismatches = 0;
    endfunction

    function void set_wps(logic [WPS_W-1:0] v);
      wps = v;
    endfunction

    function int pending();
      return pending_cells.size();
    endfunction

    // Add with clamp to the signed 40-bit range
    function logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a, longint c);
      longint s;
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (ACC_W - 1)) - 1;
      lo = -(longint'(1) <<< (ACC_W - 1));
      s = longint'(a) + c;
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return ACC_W'(s);
    endfunction

    function void take_beat(beat_t b);
      int idx;
      case (b.kind)
        KIND_HEADER: begin
          scaled_re = SCALE_W'(longint'(b.s_re) * longint'(b.dcf));
          scaled_im = SCALE_W'(longint'(b.s_im) * longint'(b.dcf));
          wx_lo = b.xl; wx_hi = b.xh; wy_lo = b.yl; wy_hi = b.yh;
          px = b.xl;
          py = b.yl;
          slots = '0;
          win_done = (b.xh < b.xl) || (b.yh < b.yl);
        end
        KIND_WEIGHT: begin
          if (!win_done && slots < wps) begin
            // only strictly positive weights touch the cell; floor shift by 16
            if (b.wgt > 0) begin
              idx = int'(px) * GRID_SIZE + int'(py);
              acc_re[idx] = sat_add(acc_re[idx], (longint'(b.wgt) * longint'(scaled_re)) >>> 16);
              acc_im[idx] = sat_add(acc_im[idx], (longint'(b.wgt) * longint'(scaled_im)) >>> 16);
            end
            // column-major walk, y fastest
            if (py == wy_hi) begin
              py = wy_lo;
              if (px == wx_hi) win_done = 1'b1;
              else px = px + 1'b1;
            end else begin
              py = py + 1'b1;
            end
          end
          if (slots != SLOT_MAX) slots = slots + 1'b1;
          if (slots >= wps) win_done = 1'b1;
        end
        KIND_READ: begin
          idx = int'(b.rx) * GRID_SIZE + int'(b.ry);
          pending_cells.push_back('{re: acc_re[idx], im: acc_im[idx]});
          if (b.clr) begin
            acc_re[idx] = '0;
            acc_im[idx] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] grid mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_cell(logic [2*ACC_W-1:0] d);
      cell_val_t e;
      if (pending_cells.size() == 0) begin
        report($sformatf("output beat %h with no read outstanding", d));
        return;
      end
      e = pending_cells.pop_front();
      if (d[ACC_W-1:0] !== e.re)
        report($sformatf("grid_real got %0d exp %0d", $signed(d[ACC_W-1:0]), e.re));
      if (d[2*ACC_W-1:ACC_W] !== e.im)
        report($sformatf("grid_imag got %0d exp %0d", $signed(d[2*ACC_W-1:ACC_W]), e.im));
    endtask

    task flush_leftovers();
      cell_val_t e;
      while (pending_cells.size() != 0) begin
        e = pending_cells.pop_front();
        report($sformatf("read result never returned (exp %0d / %0d)", e.re, e.im));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WPS_W-1:0]  cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [103:0]      s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [79:0]       m_axis_tdata;

  grid_mirror        grid_sb;
  bit                idle_on = 1'b1;
  int                rx_stall = 0;
  logic [5:0]        last_xl = '0, last_xh = '0, last_yl = '0, last_yh = '0;

  kspace_gridding_accumulator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // Output side: check each beat, stall in random bursts
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) grid_sb.check_cell(m_axis_tdata);
    if (rx_stall > 0) rx_stall--;
    else if (idle_on && $urandom_range(0, 4) == 0) rx_stall = $urandom_range(1, 11);
    m_axis_tready <= (rx_stall == 0);
  end

  // Random fields everywhere; callers override what the kind uses
  function automatic beat_t rand_beat(logic [1:0] k);
    beat_t b;
    b.kind = k;
    b.s_re = 16'($urandom);
    b.s_im = 16'($urandom);
    b.dcf  = 16'($urandom);
    b.xl   = 6'($urandom);
    b.xh   = 6'($urandom);
    b.yl   = 6'($urandom);
    b.yh   = 6'($urandom);
    b.wgt  = 16'($urandom);
    b.rx   = 6'($urandom);
    b.ry   = 6'($urandom);
    b.clr  = 1'($urandom);
    return b;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_dcf();
    case ($urandom_range(0, 7))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'h0100;
      3: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'($urandom) | 16'h8000;
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [5:0] pick_high(logic [5:0] lo);
    int hi;
    hi = ($urandom_range(0, 7) == 0) ? 63 : int'(lo) + int'($urandom_range(0, 3));
    if (hi > 63) hi = 63;
    return 6'(hi);
  endfunction

  // Present one beat, hold it until taken, then log it in the mirror
  task automatic send_beat(beat_t b);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.kind;
    s_axis_tdata  <= {3'b000, b.clr, b.ry, b.rx, b.wgt, b.yh, b.yl, b.xh, b.xl,
                      b.dcf, b.s_im, b.s_re};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    grid_sb.take_beat(b);
  endtask

  task automatic header(input logic signed [15:0] re, im, input logic [15:0] dcf,
                        input logic [5:0] xl, xh, yl, yh);
    beat_t b;
    b = rand_beat(KIND_HEADER);
    b.s_re = re; b.s_im = im; b.dcf = dcf;
    b.xl = xl; b.xh = xh; b.yl = yl; b.yh = yh;
    last_xl = xl; last_xh = xh; last_yl = yl; last_yh = yh;
    send_beat(b);
  endtask

  task automatic apply_weight(input logic signed [15:0] w);
    beat_t b;
    b = rand_beat(KIND_WEIGHT);
    b.wgt = w;
    send_beat(b);
  endtask

  task automatic read_cell(input logic [5:0] x, y, input logic clr);
    beat_t b;
    b = rand_beat(KIND_READ);
    b.rx = x; b.ry = y; b.clr = clr;
    send_beat(b);
  endtask

  // Mostly inside the last window so that reads see accumulated values
  task automatic read_near();
    logic [5:0] x, y;
    if ($urandom_range(0, 3) != 0) begin
      x = 6'($urandom_range(last_xl, last_xh));
      y = 6'($urandom_range(last_yl, last_yh));
    end else begin
      x = 6'($urandom);
      y = 6'($urandom);
    end
    read_cell(x, y, 1'($urandom));
  endtask

  // Drop valid, wait for all reads to return, let trailing updates finish
  task automatic settle(input int tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grid_sb.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_wps(input logic [WPS_W-1:0] v);
    settle(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    grid_sb.set_wps(v);
  endtask

  // Header + weight runs with random content, reads mixed in, some noise
  task automatic random_traffic(input int n);
    int done_items, pick, cells, n_w;
    logic [5:0] xl, xh, yl, yh;
    done_items = 0;
    while (done_items < n) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_beat(rand_beat(KIND_UNUSED));
      end else if (pick <= 3) begin
        read_near();
        done_items++;
      end else begin
        xl = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        yl = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        xh = pick_high(xl);
        yh = pick_high(yl);
        // occasionally an inverted range
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) xh = xl - 1'b1;
          else yh = yl - 1'b1;
        end
        header(rand_sample(), rand_sample(), rand_dcf(), xl, xh, yl, yh);
        done_items++;
        cells = (xh >= xl && yh >= yl) ?
                (int'(xh) - int'(xl) + 1) * (int'(yh) - int'(yl) + 1) : 2;
        if (cells > 40) cells = 40;
        n_w = ($urandom_range(0, 3) != 0) ? cells + int'($urandom_range(0, 2))
                                          : int'($urandom_range(0, cells));
        repeat (n_w) begin
          if ($urandom_range(0, 7) == 0) begin
            read_near();
            done_items++;
          end
          apply_weight(rand_weight());
          done_items++;
        end
      end
    end
  endtask

  initial begin
    grid_sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fresh grid, ignored kind, empty windows
    read_cell(6'd0, 6'd0, 1'b0);
    send_beat(rand_beat(KIND_UNUSED));
    header(16'sd100, 16'sd100, 16'h0100, 6'd5, 6'd4, 6'd0, 6'd0);
    apply_weight(16'sd16384);
    read_cell(6'd5, 6'd0, 1'b0);
    header(16'sd100, -16'sd100, 16'h0100, 6'd0, 6'd0, 6'd9, 6'd8);
    apply_weight(16'sh7fff);

    // Largest contribution at the far corner, then read-and-clear
    header(16'sh7fff, 16'sh8000, 16'hffff, 6'd63, 6'd63, 6'd63, 6'd63);
    apply_weight(16'sh7fff);
    apply_weight(16'sh7fff);
    read_cell(6'd63, 6'd63, 1'b1);
    read_cell(6'd63, 6'd63, 1'b0);

    // 2x2 window with positive, zero, negative and tiny weights, one extra
    header(16'sh8000, 16'sh7fff, 16'hffff, 6'd0, 6'd1, 6'd62, 6'd63);
    apply_weight(16'sh7fff);
    apply_weight(16'sd0);
    apply_weight(16'sh8000);
    apply_weight(16'sd1);
    apply_weight(16'sd20000);

    // Zero density factor; then floor rounding of a tiny negative product
    header(-16'sd1, -16'sd1, 16'h0000, 6'd0, 6'd1, 6'd0, 6'd1);
    apply_weight(16'sh7fff);
    header(-16'sd1, 16'sd1, 16'h0001, 6'd2, 6'd2, 6'd3, 6'd3);
    apply_weight(16'sd1);
    read_cell(6'd2, 6'd3, 1'b1);
    read_cell(6'd0, 6'd62, 1'b1);
    read_cell(6'd0, 6'd63, 1'b1);
    read_cell(6'd1, 6'd62, 1'b1);
    read_cell(6'd1, 6'd63, 1'b1);

    // Random phases across register settings
    write_wps(11'd3);
    random_traffic(30);
    write_wps(11'd1);
    random_traffic(25);
    write_wps(11'd1024);
    idle_on = 1'b0;
    random_traffic(15);
    idle_on = 1'b1;
    random_traffic(25);

    // Drive one cell into both saturation limits
    for (int i = 0; i < 530; i++) begin
      header(16'sh7fff, 16'sh8000, 16'hffff, 6'd5, 6'd5, 6'd9, 6'd9);
      apply_weight(16'sh7fff);
      if (i % 100 == 99) read_cell(6'd5, 6'd9, 1'b0);
    end
    read_cell(6'd5, 6'd9, 1'b1);
    read_cell(6'd5, 6'd9, 1'b0);

    // Closing stretch without any idling
    write_wps(11'($urandom_range(2, 40)));
    idle_on = 1'b0;
    random_traffic(35);

    settle(16);
    grid_sb.flush_leftovers();
    if (grid_sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[kspace_gridding_accumulator_unit.f]
rtl/kga_pkg.sv
rtl/kga_window.sv
rtl/kga_accum.sv
rtl/kspace_gridding_accumulator_unit.sv
rtl/kga_checker.sv
sim/tb.sv
